[design/assert_macros.svh]
// Assertion helpers included by the frame encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ANY(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("assertion failed");

`endif

[design/wse_pkg.sv]
package wse_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 24;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int MSG_BITS    = 48;
    localparam int DIG_BITS    = 40;
    localparam logic [4:0] LAST_IDX = 5'(FRAME_BYTES - 1);

    localparam logic [11:0] FIRST_PRE = 12'h001;
    localparam logic [14:0] REP_PRE   = 15'h1FFD;

    // digest constants
    localparam logic [7:0] DIGEST_GEN = 8'h98;
    localparam logic [7:0] DIGEST_KEY = 8'h3E;
    localparam logic [7:0] DIGEST_XOR = 8'h64;

    // raw = trunc(t*9/50) + 720; x/50 as (x*DIV_MUL) >> DIV_SHIFT, exact for x < 2^18
    localparam logic [11:0] RAW_OFFSET = 12'd720;
    localparam logic [18:0] DIV_MUL    = 19'd335545;
    localparam int          DIV_SHIFT  = 24;

    // register indexes (word address bits 3:2)
    localparam logic [1:0] REG_MODEL = 2'd0;
    localparam logic [1:0] REG_ID    = 2'd1;
    localparam logic [1:0] REG_CHAN  = 2'd2;
    localparam logic [1:0] REG_HUM   = 2'd3;

    localparam logic [7:0] MODEL_RST = 8'd70;
    localparam logic [7:0] ID_RST    = 8'd72;
    localparam logic [2:0] CHAN_RST  = 3'd0;
    localparam logic [7:0] HUM_RST   = 8'd50;

    typedef struct packed {
        logic [7:0] model;
        logic [7:0] id;
        logic [2:0] chan;
        logic [7:0] hum;
    } cfg_t;

    // converted temperature: sign and magnitude of trunc(t*9/50)
    typedef struct packed {
        logic        neg;
        logic [12:0] mag;
    } conv_t;

    typedef logic [DIG_BITS-1:0][7:0] key_arr_t;

    // key sequence of the digest LFSR, one key per bit of the first five message bytes
    function automatic key_arr_t make_keys();
        key_arr_t   keys;
        logic [7:0] key;
        key = DIGEST_KEY;
        for (int i = 0; i < DIG_BITS; i++) begin
            keys[i] = key;
            if (key[0]) begin
                key = (key >> 1) ^ DIGEST_GEN;
            end else begin
                key = key >> 1;
            end
        end
        return keys;
    endfunction

    localparam key_arr_t DIGEST_KEYS = make_keys();

    // Manchester word for one frame byte: 1 -> 10, 0 -> 01, MSB first
    function automatic logic [15:0] frame_word(logic [MSG_BITS-1:0] msg, logic [4:0] idx);
        logic [FRAME_BITS-1:0] frame;
        logic [7:0]            off;
        logic [7:0]            fbyte;
        logic [15:0]           word;
        frame = {FIRST_PRE, msg, 2'b00, REP_PRE, msg, 2'b00, REP_PRE, msg, 2'b00};
        off   = {3'b000, LAST_IDX - idx} << 3;
        fbyte = frame[off +: 8];
        for (int j = 0; j < 8; j++) begin
            word[2*j+1] = fbyte[j];
            word[2*j]   = ~fbyte[j];
        end
        return word;
    endfunction

endpackage

[design/wse_temp_conv.sv]
module wse_temp_conv (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [14:0]         in_temp,
    output logic                out_valid,
    input  logic                out_ready,
    output wse_pkg::conv_t      out_conv
);

    logic           temp_valid_reg;
    logic [14:0]    temp_reg;
    logic           conv_valid_reg;
    wse_pkg::conv_t conv_reg;
    wse_pkg::conv_t conv_next;
    logic           conv_ready;

    logic [14:0]    mag;
    logic [17:0]    times9;
    logic [36:0]    prod;

    assign conv_ready = !conv_valid_reg || out_ready;
    assign in_ready   = !temp_valid_reg || conv_ready;

    // magnitude * 9, then divide by 50 through the reciprocal
    always_comb begin
        mag    = temp_reg[14] ? (~temp_reg + 15'd1) : temp_reg;
        times9 = {mag, 3'b000} + {3'b000, mag};
        prod   = 37'(times9) * 37'(wse_pkg::DIV_MUL);
        conv_next.neg = temp_reg[14];
        conv_next.mag = prod[wse_pkg::DIV_SHIFT +: 13];
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_valid_reg <= 1'b0;
        end else if (in_ready) begin
            temp_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            temp_reg <= in_temp;
        end
    end

    // quotient stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_valid_reg <= 1'b0;
        end else if (conv_ready) begin
            conv_valid_reg <= temp_valid_reg;
        end
        if (conv_ready && temp_valid_reg) begin
            conv_reg <= conv_next;
        end
    end

    assign out_valid = conv_valid_reg;
    assign out_conv  = conv_reg;

endmodule

[design/wse_msg_build.sv]
module wse_msg_build (
    input  logic                aclk,
    input  logic                aresetn,
    input  wse_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  wse_pkg::conv_t      in_conv,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [47:0]         out_msg
);

    logic        msg_valid_reg;
    logic [47:0] msg_reg;
    logic [47:0] msg_next;
    logic [11:0] raw;
    logic [39:0] head;
    logic [7:0]  digest;

    assign in_ready = !msg_valid_reg || out_ready;

    // raw value, first five bytes and digest
    always_comb begin
        raw = in_conv.neg ? (wse_pkg::RAW_OFFSET - in_conv.mag[11:0])
                          : (wse_pkg::RAW_OFFSET + in_conv.mag[11:0]);
        head = {cfg.model, cfg.id, 1'b0, cfg.chan, raw[11:8], raw[7:0], cfg.hum};
        digest = 8'h00;
        for (int i = 0; i < wse_pkg::DIG_BITS; i++) begin
            if (head[wse_pkg::DIG_BITS-1-i]) begin
                digest = digest ^ wse_pkg::DIGEST_KEYS[i];
            end
        end
        msg_next = {head, digest ^ wse_pkg::DIGEST_XOR};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_valid_reg <= 1'b0;
        end else if (in_ready) begin
            msg_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            msg_reg <= msg_next;
        end
    end

    assign out_valid = msg_valid_reg;
    assign out_msg   = msg_reg;

endmodule

[design/wse_serializer.sv]
module wse_serializer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] in_msg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_idx,
    output logic [15:0] out_word,
    output logic        out_last
);

    logic        busy_reg;
    logic [4:0]  idx_reg;
    logic [47:0] msg_reg;
    logic        is_last;

    assign is_last  = (idx_reg == wse_pkg::LAST_IDX);
    // a new message loads as the final word of the current one leaves
    assign in_ready = !busy_reg || (out_ready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 5'd0;
        end else if (in_ready && in_valid) begin
            busy_reg <= 1'b1;
            idx_reg  <= 5'd0;
        end else if (busy_reg && out_ready) begin
            if (is_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 5'd1;
            end
        end
        if (in_ready && in_valid) begin
            msg_reg <= in_msg;
        end
    end

    assign out_valid = busy_reg;
    assign out_idx   = idx_reg;
    assign out_word  = wse_pkg::frame_word(msg_reg, idx_reg);
    assign out_last  = is_last;

endmodule

[design/weather_sensor_ook_frame_encoder_core.sv]
// Channel   Direction  Word
// s_axis    in         tdata[14:0] temp_centi (signed), rest zero
// m_axis    out        tdata[4:0] byte_index, [20:5] coded_word; tlast = last_word
// apb       in         regs at 0x0 model, 0x4 id, 0x8 channel, 0xC humidity
//
// Each temperature word yields 24 coded words, one per cycle while m_tready is high.
// The word serializer emits them.
// After the input is taken it passes the input, quotient, message and serializer registers;
// the next input is converted meanwhile and follows the previous frame's last word
// with no gap.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
// A stall on m_tready holds the current word and backs up into s_tready.
`include "assert_macros.svh"

module weather_sensor_ook_frame_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s: [14:0] temp_centi, [15] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // m: [4:0] byte_index, [20:5] coded_word, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wse_pkg::cfg_t  cfg_reg;
    logic           cfg_wr;

    logic           conv_valid;
    logic           conv_ready;
    wse_pkg::conv_t conv;
    logic           msg_valid;
    logic           msg_ready;
    logic [47:0]    msg;
    logic [4:0]     byte_index;
    logic [15:0]    coded_word;

    logic           word_taken;
    logic [4:0]     idx_inc;
    logic [15:0]    pair_diff;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.model <= wse_pkg::MODEL_RST;
            cfg_reg.id    <= wse_pkg::ID_RST;
            cfg_reg.chan  <= wse_pkg::CHAN_RST;
            cfg_reg.hum   <= wse_pkg::HUM_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                wse_pkg::REG_MODEL: cfg_reg.model <= pwdata[7:0];
                wse_pkg::REG_ID:    cfg_reg.id    <= pwdata[7:0];
                wse_pkg::REG_CHAN:  cfg_reg.chan  <= pwdata[2:0];
                wse_pkg::REG_HUM:   cfg_reg.hum   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[3:2])
            wse_pkg::REG_MODEL: prdata = {24'd0, cfg_reg.model};
            wse_pkg::REG_ID:    prdata = {24'd0, cfg_reg.id};
            wse_pkg::REG_CHAN:  prdata = {29'd0, cfg_reg.chan};
            wse_pkg::REG_HUM:   prdata = {24'd0, cfg_reg.hum};
            default:            prdata = 32'd0;
        endcase
    end

    wse_temp_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_temp   (s_tdata[14:0]),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_conv  (conv)
    );

    wse_msg_build u_msg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (conv_valid),
        .in_ready  (conv_ready),
        .in_conv   (conv),
        .out_valid (msg_valid),
        .out_ready (msg_ready),
        .out_msg   (msg)
    );

    wse_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (msg_valid),
        .in_ready  (msg_ready),
        .in_msg    (msg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (byte_index),
        .out_word  (coded_word),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, coded_word, byte_index};

    // checks
    assign word_taken = m_tvalid && m_tready;
    assign idx_inc    = byte_index + 5'd1;
    assign pair_diff  = coded_word ^ (coded_word >> 1);

    `ASSERT_CLK(a_last_idx, m_tvalid && m_tlast |-> byte_index == wse_pkg::LAST_IDX)
    `ASSERT_CLK(a_idx_step, word_taken && !m_tlast |=> m_tvalid && byte_index == $past(idx_inc))
    `ASSERT_CLK(a_manchester, m_tvalid |-> (pair_diff & 16'h5555) == 16'h5555)
    `ASSERT_ANY(a_reset_idle, !aresetn |=> !m_tvalid)

endmodule

[dv/tb_weather_sensor_ook_frame_encoder_core.sv]
module tb_weather_sensor_ook_frame_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    // frame and digest constants
    localparam logic [7:0]  LFSR_GEN   = 8'h98;
    localparam logic [7:0]  LFSR_KEY   = 8'h3E;
    localparam logic [7:0]  LFSR_XOR   = 8'h64;
    localparam int          RAW_BIAS   = 720;
    localparam logic [11:0] PRE_FIRST  = 12'h001;
    localparam logic [14:0] PRE_REPEAT = 15'h1FFD;
    localparam int          NUM_WORDS  = 24;
    localparam int          LONG_HOLD  = 300;

    typedef struct packed {
        logic [4:0]  byte_index;
        logic [15:0] coded_word;
        logic        last_word;
    } coded_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [14:0] temp_centi, [15] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [4:0] byte_index, [20:5] coded_word, [23:21] zero
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // register shadow used for prediction
    logic [7:0] cfg_model = wse_pkg::MODEL_RST;
    logic [7:0] cfg_id    = wse_pkg::ID_RST;
    logic [2:0] cfg_chan  = wse_pkg::CHAN_RST;
    logic [7:0] cfg_hum   = wse_pkg::HUM_RST;

    logic [14:0] pending_temps[$];
    coded_word_t expected_words[$];

    int  send_wait      = 0;
    int  recv_wait      = 0;
    bit  tx_idle_on     = 0;
    bit  rx_idle_on     = 0;
    int  hold_requests  = 0;
    int  holds_done     = 0;
    int  mismatch_count = 0;
    int  temps_sent     = 0;
    int  words_checked  = 0;
    int  settings_used  = 0;

    weather_sensor_ook_frame_encoder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // digest over the first five message bytes, MSB first
    function automatic logic [7:0] msg_digest(logic [39:0] data);
        logic [7:0] sum;
        logic [7:0] key;
        sum = '0;
        key = LFSR_KEY;
        for (int i = 39; i >= 0; i--) begin
            if (data[i]) begin
                sum ^= key;
            end
            key = key[0] ? ((key >> 1) ^ LFSR_GEN) : (key >> 1);
        end
        return sum;
    endfunction

    // expected 24 coded words for one temperature under the current settings
    function automatic void encode_frame(logic [14:0] temp);
        int           centi;
        int           scaled;
        logic [11:0]  raw;
        logic [39:0]  head;
        logic [47:0]  msg;
        logic [191:0] frame;
        logic [7:0]   fbyte;
        coded_word_t  cw;
        centi  = $signed(temp);
        scaled = (centi * 18) / 100;   // truncates toward zero
        raw    = 12'(scaled + RAW_BIAS);
        // battery bit always zero (battery good)
        head   = {cfg_model, cfg_id, 1'b0, cfg_chan, raw, cfg_hum};
        msg    = {head, msg_digest(head) ^ LFSR_XOR};
        frame  = {PRE_FIRST, msg, 2'b00, PRE_REPEAT, msg, 2'b00, PRE_REPEAT, msg, 2'b00};
        for (int k = 0; k < NUM_WORDS; k++) begin
            fbyte = frame[191 - 8*k -: 8];
            cw.byte_index = 5'(k);
            cw.coded_word = '0;
            for (int j = 7; j >= 0; j--) begin
                cw.coded_word = {cw.coded_word[13:0], fbyte[j] ? 2'b10 : 2'b01};
            end
            cw.last_word = (k == NUM_WORDS - 1);
            expected_words.push_back(cw);
        end
    endfunction

    function automatic int draw_gap(bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic void flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endfunction

    // temperature driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_frame(s_tdata[14:0]);
                temps_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_temps.size() > 0) begin
                    s_tdata   <= {1'b0, pending_temps.pop_front()};
                    s_tvalid  <= 1'b1;
                    send_wait = draw_gap(tx_idle_on);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // coded word monitor and back-pressure
    always @(posedge aclk) begin
        coded_word_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word tdata=%h tlast=%b",
                                            m_tdata, m_tlast));
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[4:0] !== want.byte_index) begin
                        flag_mismatch($sformatf("byte_index exp %0d got %0d",
                                                want.byte_index, m_tdata[4:0]));
                    end
                    if (m_tdata[20:5] !== want.coded_word) begin
                        flag_mismatch($sformatf("coded_word[%0d] exp %h got %h",
                                                want.byte_index, want.coded_word,
                                                m_tdata[20:5]));
                    end
                    if (m_tlast !== want.last_word) begin
                        flag_mismatch($sformatf("last_word[%0d] exp %b got %b",
                                                want.byte_index, want.last_word, m_tlast));
                    end
                end
                recv_wait = draw_gap(rx_idle_on);
            end
            // long hold-off requested by the sequence
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                recv_wait  = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // APB write: setup then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wse_pkg::REG_MODEL: cfg_model = value[7:0];
            wse_pkg::REG_ID:    cfg_id    = value[7:0];
            wse_pkg::REG_CHAN:  cfg_chan  = value[2:0];
            wse_pkg::REG_HUM:   cfg_hum   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] model, logic [31:0] id,
                             logic [31:0] chan, logic [31:0] hum);
        write_reg(wse_pkg::REG_MODEL, model);
        write_reg(wse_pkg::REG_ID, id);
        write_reg(wse_pkg::REG_CHAN, chan);
        write_reg(wse_pkg::REG_HUM, hum);
        settings_used++;
    endtask

    // block idle: nothing queued, nothing in flight, nothing outstanding
    task automatic wait_idle();
        while (pending_temps.size() != 0 || s_tvalid || expected_words.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [14:0] random_temp();
        if ($urandom_range(0, 3) == 0) begin
            return 15'($urandom);
        end
        return 15'($urandom_range(0, 16000) - 4000);
    endfunction

    // stimulus sequence
    initial begin
        logic [14:0] directed_a[$];
        directed_a = '{15'(-4000), 15'(12000), 15'(0), 15'(-1), 15'(1),
                       15'h3FFF, 15'h4000, 15'(-5), 15'(-6), 15'(6)};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, full rate
        tx_idle_on = 0;
        rx_idle_on = 0;
        foreach (directed_a[i]) pending_temps.push_back(directed_a[i]);
        wait_idle();

        // directed: all-zero registers
        write_all(32'h0, 32'h0, 32'h0, 32'h0);
        pending_temps.push_back(15'(100));
        pending_temps.push_back(15'(-100));
        pending_temps.push_back(15'(-10000));
        pending_temps.push_back(15'h2AAA);
        pending_temps.push_back(15'h5555);
        wait_idle();

        // directed: all-ones registers, upper bits must be dropped
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_temps.push_back(15'(-4000));
        pending_temps.push_back(15'(12000));
        pending_temps.push_back(15'(2222));
        pending_temps.push_back(15'(-16384));
        pending_temps.push_back(15'(16383));
        wait_idle();

        // random phases with varying settings and idling
        for (int p = 0; p < 5; p++) begin
            write_all($urandom, $urandom, $urandom, $urandom);
            tx_idle_on = (p == 0 || p == 3 || p == 4);
            rx_idle_on = (p == 0 || p == 1 || p == 4);
            if (p == 2) begin
                // receiver holds off while items keep coming, input must back up
                hold_requests++;
            end
            for (int i = 0; i < 32; i++) begin
                pending_temps.push_back(random_temp());
            end
            wait_idle();
        end

        // drain window for any stray words
        repeat (30) @(posedge aclk);

        $display("Covered %0d temperatures and %0d coded words over %0d register settings,",
                 temps_sent, words_checked, settings_used + 1);
        $display("including a long output stall and randomized gaps on both sides.");
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatch_count,
                     expected_words.size());
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d words still outstanding", expected_words.size());
        $display("Verification failed");
        $finish;
    end

endmodule
